FILE: rtl/core/pisc_pkg.sv
// Shared types and constants for the point-in-solid classifier
package pisc_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned NODE_W         = 24;
  localparam int unsigned AXIS_W         = 16;
  localparam int unsigned AXIS_FRAC      = 14;
  localparam int unsigned AXIS_PACK_W    = 3 * AXIS_W;
  localparam int unsigned CFG_DATA_W     = 48;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned N_STAGES       = 7;
  // slice width used when the dish product is split into partial products
  localparam int unsigned MUL_CHUNK      = 32;

  typedef enum logic [1:0] {
    SHAPE_SPHERE,
    SHAPE_CYLINDER,
    SHAPE_BOX,
    SHAPE_DISH
  } shape_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_KIND,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_AXIS_PACKED,
    REG_SIZE_A,
    REG_SIZE_B,
    REG_SIZE_C
  } cfg_reg_e;

  // per-shape partial verdicts carried down the pipe
  typedef struct packed {
    logic sph_ok;
    logic cyl_ok;
    logic box_ok;
    logic dish_ok;
  } test_flags_t;

endpackage

FILE: rtl/core/pisc_front.sv
// Stages 1-3: offset from centre, axis products, dot/cross and sphere test
module pisc_front #(
  parameter int unsigned COORD_BITS = pisc_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic [2:0]                              en_i,
  input  logic signed [COORD_BITS-1:0]            point_x_i,
  input  logic signed [COORD_BITS-1:0]            point_y_i,
  input  logic signed [COORD_BITS-1:0]            point_z_i,
  input  logic signed [COORD_BITS-1:0]            center_x_i,
  input  logic signed [COORD_BITS-1:0]            center_y_i,
  input  logic signed [COORD_BITS-1:0]            center_z_i,
  input  logic [pisc_pkg::AXIS_PACK_W-1:0]        axis_i,
  input  logic [2*COORD_BITS-1:0]                 size_a_sq_i,
  output logic signed [COORD_BITS+18:0]           dot_o,
  output logic signed [COORD_BITS+17:0]           cross_x_o,
  output logic signed [COORD_BITS+17:0]           cross_y_o,
  output logic signed [COORD_BITS+17:0]           cross_z_o,
  output logic signed [COORD_BITS:0]              ry_o,
  output logic signed [COORD_BITS:0]              rz_o,
  output logic                                    sph_ok_o
);

  localparam int unsigned AW    = pisc_pkg::AXIS_W;
  localparam int unsigned REL_W = COORD_BITS + 1;
  localparam int unsigned PR_W  = REL_W + AW;
  localparam int unsigned DOT_W = PR_W + 2;
  localparam int unsigned CR_W  = PR_W + 1;
  localparam int unsigned RS_W  = 2 * REL_W;
  localparam int unsigned SS_W  = RS_W + 2;

  logic signed [AW-1:0] nx, ny, nz;

  // stage 1
  logic signed [REL_W-1:0] rx_q, ry1_q, rz1_q;
  // stage 2
  logic signed [PR_W-1:0]  pxx_q, pxy_q, pxz_q, pyx_q, pyy_q, pyz_q, pzx_q, pzy_q, pzz_q;
  logic [RS_W-1:0]         sqx_q, sqy_q, sqz_q;
  logic signed [REL_W-1:0] ry2_q, rz2_q;
  // stage 3
  logic signed [DOT_W-1:0] dot_q;
  logic signed [CR_W-1:0]  cx_q, cy_q, cz_q;
  logic signed [REL_W-1:0] ry3_q, rz3_q;
  logic                    sph_q;
  logic [SS_W-1:0]         sph_sum;

  assign nx = axis_i[AW-1:0];
  assign ny = axis_i[2*AW-1:AW];
  assign nz = axis_i[3*AW-1:2*AW];

  // stage 1: offset of the node from the centre
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rx_q  <= REL_W'(point_x_i) - REL_W'(center_x_i);
      ry1_q <= REL_W'(point_y_i) - REL_W'(center_y_i);
      rz1_q <= REL_W'(point_z_i) - REL_W'(center_z_i);
    end
  end

  // stage 2: the nine offset-by-axis products and the squared offsets
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pxx_q <= PR_W'(rx_q)  * PR_W'(nx);
      pxy_q <= PR_W'(rx_q)  * PR_W'(ny);
      pxz_q <= PR_W'(rx_q)  * PR_W'(nz);
      pyx_q <= PR_W'(ry1_q) * PR_W'(nx);
      pyy_q <= PR_W'(ry1_q) * PR_W'(ny);
      pyz_q <= PR_W'(ry1_q) * PR_W'(nz);
      pzx_q <= PR_W'(rz1_q) * PR_W'(nx);
      pzy_q <= PR_W'(rz1_q) * PR_W'(ny);
      pzz_q <= PR_W'(rz1_q) * PR_W'(nz);
      sqx_q <= RS_W'(RS_W'(rx_q)  * RS_W'(rx_q));
      sqy_q <= RS_W'(RS_W'(ry1_q) * RS_W'(ry1_q));
      sqz_q <= RS_W'(RS_W'(rz1_q) * RS_W'(rz1_q));
      ry2_q <= ry1_q;
      rz2_q <= rz1_q;
    end
  end

  assign sph_sum = SS_W'(sqx_q) + SS_W'(sqy_q) + SS_W'(sqz_q);

  // stage 3: dot, cross and the sphere verdict
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dot_q <= DOT_W'(pxx_q) + DOT_W'(pyy_q) + DOT_W'(pzz_q);
      cx_q  <= CR_W'(pyz_q) - CR_W'(pzy_q);
      cy_q  <= CR_W'(pzx_q) - CR_W'(pxz_q);
      cz_q  <= CR_W'(pxy_q) - CR_W'(pyx_q);
      sph_q <= sph_sum <= SS_W'(size_a_sq_i);
      ry3_q <= ry2_q;
      rz3_q <= rz2_q;
    end
  end

  assign dot_o     = dot_q;
  assign cross_x_o = cx_q;
  assign cross_y_o = cy_q;
  assign cross_z_o = cz_q;
  assign ry_o      = ry3_q;
  assign rz_o      = rz3_q;
  assign sph_ok_o  = sph_q;

endmodule

FILE: rtl/core/pisc_mid.sv
// Stages 4-5: radial distance squared, axial extents and box planes
module pisc_mid #(
  parameter int unsigned COORD_BITS = pisc_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic [1:0]                              en_i,
  input  logic signed [COORD_BITS+18:0]           dot_i,
  input  logic signed [COORD_BITS+17:0]           cross_x_i,
  input  logic signed [COORD_BITS+17:0]           cross_y_i,
  input  logic signed [COORD_BITS+17:0]           cross_z_i,
  input  logic signed [COORD_BITS:0]              ry_i,
  input  logic signed [COORD_BITS:0]              rz_i,
  input  logic                                    sph_ok_i,
  input  logic [pisc_pkg::AXIS_PACK_W-1:0]        axis_i,
  input  logic [COORD_BITS-1:0]                   size_a_i,
  input  logic [COORD_BITS-1:0]                   size_b_i,
  input  logic [COORD_BITS-1:0]                   size_c_i,
  output logic signed [COORD_BITS+18:0]           dot_o,
  output logic [2*COORD_BITS+37:0]                sumsq_o,
  output pisc_pkg::test_flags_t                   flags_o
);

  localparam int unsigned AW    = pisc_pkg::AXIS_W;
  localparam int unsigned AF    = pisc_pkg::AXIS_FRAC;
  localparam int unsigned REL_W = COORD_BITS + 1;
  localparam int unsigned PR_W  = REL_W + AW;
  localparam int unsigned DOT_W = PR_W + 2;
  localparam int unsigned CR_W  = PR_W + 1;
  localparam int unsigned H     = (CR_W + 1) / 2;
  localparam int unsigned HI_W  = CR_W - H;
  localparam int unsigned SQ1_W = 2 * CR_W;
  localparam int unsigned SQ_W  = SQ1_W + 2;
  localparam int unsigned ND_W  = AW + DOT_W;
  localparam int unsigned SEC_W = ND_W + 1;

  logic signed [AW-1:0]   ny, nz;
  logic signed [CR_W-1:0] cr [3];
  logic [CR_W-1:0]        cm [3];
  logic [DOT_W-1:0]       dmag;

  // stage 4
  logic [2*H-1:0]           ll_q [3];
  logic [H+HI_W-1:0]        lh_q [3];
  logic [2*HI_W-1:0]        hh_q [3];
  logic signed [ND_W-1:0]   ndy_q, ndz_q;
  logic signed [DOT_W-1:0]  dot4_q;
  logic signed [REL_W-1:0]  ry4_q, rz4_q;
  pisc_pkg::test_flags_t    fl4_q;

  // stage 5
  logic [SQ1_W-1:0]         sq [3];
  logic signed [SEC_W-1:0]  sec_y, sec_z;
  logic [SEC_W-1:0]         sab_y, sab_z;
  logic                     ok_y, ok_z;
  logic [SQ_W-1:0]          sumsq_q;
  logic signed [DOT_W-1:0]  dot5_q;
  pisc_pkg::test_flags_t    fl5_q;

  assign ny = axis_i[2*AW-1:AW];
  assign nz = axis_i[3*AW-1:2*AW];
  assign cr[0] = cross_x_i;
  assign cr[1] = cross_y_i;
  assign cr[2] = cross_z_i;

  // cross magnitudes, split in halves for the squaring
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i] = cr[i][CR_W-1] ? CR_W'(-cr[i]) : CR_W'(cr[i]);
    end
    dmag = dot_i[DOT_W-1] ? DOT_W'(-dot_i) : DOT_W'(dot_i);
  end

  // stage 4: square partials, axis-by-dot products, axial range checks
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        ll_q[i] <= (2*H)'(cm[i][H-1:0]) * (2*H)'(cm[i][H-1:0]);
        lh_q[i] <= (H+HI_W)'(cm[i][H-1:0]) * (H+HI_W)'(cm[i][CR_W-1:H]);
        hh_q[i] <= (2*HI_W)'(cm[i][CR_W-1:H]) * (2*HI_W)'(cm[i][CR_W-1:H]);
      end
      ndy_q          <= ND_W'(ny) * ND_W'(dot_i);
      ndz_q          <= ND_W'(nz) * ND_W'(dot_i);
      dot4_q         <= dot_i;
      ry4_q          <= ry_i;
      rz4_q          <= rz_i;
      fl4_q.sph_ok   <= sph_ok_i;
      // cylinder: half height; box: half depth; dish: 0 <= dot <= depth
      fl4_q.cyl_ok   <= {dmag, 1'b0} <= {size_b_i, {AF{1'b0}}};
      fl4_q.box_ok   <= {dmag, 1'b0} <= {size_c_i, {AF{1'b0}}};
      fl4_q.dish_ok  <= !dot_i[DOT_W-1] && (dot_i[DOT_W-2:0] <= {size_a_i, {AF{1'b0}}});
    end
  end

  // recombine the square partials
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = (SQ1_W'(hh_q[i]) << (2*H)) + (SQ1_W'(lh_q[i]) << (H+1)) + SQ1_W'(ll_q[i]);
    end
  end

  // box planes: offset less its axial part, against half width and height
  assign sec_z = (SEC_W'(rz4_q) <<< (2*AF)) - SEC_W'(ndz_q);
  assign sec_y = (SEC_W'(ry4_q) <<< (2*AF)) - SEC_W'(ndy_q);
  assign sab_z = sec_z[SEC_W-1] ? SEC_W'(-sec_z) : SEC_W'(sec_z);
  assign sab_y = sec_y[SEC_W-1] ? SEC_W'(-sec_y) : SEC_W'(sec_y);
  assign ok_z  = {sab_z, 1'b0} <= {size_a_i, {2*AF{1'b0}}};
  assign ok_y  = {sab_y, 1'b0} <= {size_b_i, {2*AF{1'b0}}};

  // stage 5
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sumsq_q       <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
      dot5_q        <= dot4_q;
      fl5_q.sph_ok  <= fl4_q.sph_ok;
      fl5_q.cyl_ok  <= fl4_q.cyl_ok;
      fl5_q.box_ok  <= fl4_q.box_ok && ok_z && ok_y;
      fl5_q.dish_ok <= fl4_q.dish_ok;
    end
  end

  assign dot_o   = dot5_q;
  assign sumsq_o = sumsq_q;
  assign flags_o = fl5_q;

endmodule

FILE: rtl/core/pisc_back.sv
// Stages 6-7: cylinder radius, dish product and final verdict
module pisc_back #(
  parameter int unsigned COORD_BITS = pisc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pisc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic [1:0]                    en_i,
  input  logic signed [COORD_BITS+18:0] dot_i,
  input  logic [2*COORD_BITS+37:0]      sumsq_i,
  input  pisc_pkg::test_flags_t         flags_i,
  input  logic [COORD_BITS-1:0]         size_b_i,
  input  logic [2*COORD_BITS-1:0]       size_a_sq_i,
  input  pisc_pkg::shape_e              kind_i,
  output logic                          inside_o
);

  localparam int unsigned AF    = pisc_pkg::AXIS_FRAC;
  localparam int unsigned MC    = pisc_pkg::MUL_CHUNK;
  localparam int unsigned DOT_W = COORD_BITS + 19;
  localparam int unsigned SQ_W  = 2 * COORD_BITS + 38;
  localparam int unsigned SB_W  = COORD_BITS + 2;
  localparam int unsigned NCH   = (SQ_W + MC - 1) / MC;
  localparam int unsigned PADW  = NCH * MC;
  localparam int unsigned PP_W  = MC + SB_W;
  localparam int unsigned LHS_W = PADW + SB_W;
  localparam int unsigned SH    = 2 * FRAC_BITS + AF;

  logic [PADW-1:0]          sq_pad;
  logic [SB_W-1:0]          sb4;
  logic [PP_W-1:0]          pp_q [NCH];
  logic signed [DOT_W-1:0]  dot6_q;
  pisc_pkg::test_flags_t    fl6_q;
  logic [LHS_W-1:0]         lhs;
  logic                     dish_ok;
  logic                     inside_d, inside_q;

  assign sq_pad = PADW'(sumsq_i);
  assign sb4    = {size_b_i, 2'b00};

  // stage 6: radial square times 4*focal length, in slices
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < NCH; k++) begin
        pp_q[k] <= PP_W'(sq_pad[k*MC +: MC]) * PP_W'(sb4);
      end
      dot6_q        <= dot_i;
      fl6_q.sph_ok  <= flags_i.sph_ok;
      fl6_q.cyl_ok  <= flags_i.cyl_ok && (sumsq_i <= {size_a_sq_i, {2*AF{1'b0}}});
      fl6_q.box_ok  <= flags_i.box_ok;
      fl6_q.dish_ok <= flags_i.dish_ok;
    end
  end

  // sum the slices; dot is known non-negative when the dish flag is set
  always_comb begin
    lhs = '0;
    for (int k = 0; k < NCH; k++) begin
      lhs = lhs + (LHS_W'(pp_q[k]) << (k*MC));
    end
  end

  assign dish_ok = fl6_q.dish_ok && (lhs <= {dot6_q[DOT_W-2:0], {SH{1'b0}}});

  // pick the verdict of the configured shape
  always_comb begin
    unique case (kind_i)
      pisc_pkg::SHAPE_SPHERE:   inside_d = fl6_q.sph_ok;
      pisc_pkg::SHAPE_CYLINDER: inside_d = fl6_q.cyl_ok;
      pisc_pkg::SHAPE_BOX:      inside_d = fl6_q.box_ok;
      pisc_pkg::SHAPE_DISH:     inside_d = dish_ok;
      default:                  inside_d = 1'b0;
    endcase
  end

  // stage 7: output register
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      inside_q <= inside_d;
    end
  end

  assign inside_o = inside_q;

endmodule

FILE: rtl/core/point_in_solid_classifier_core.sv
// Channel | Handshake                  | Beat payload
// --------+----------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o    | node_index_i, point_x_i, point_y_i, point_z_i
// out     | out_valid_o / out_stall_i  | node_out_o, inside_res_o
// cfg     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// Seven register stages; one beat is taken every cycle while in_stall_o is
// low. The pipe depth is set by the dot/cross products, the split squaring
// of the cross and the split dish multiply.
// Each stage holds while the one after it is full and stalled, so gaps
// close up under a stall. Reset clears the valid bits and the configuration
// registers; the datapath registers are not reset.
module point_in_solid_classifier_core #(
  parameter int unsigned COORD_BITS = pisc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pisc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pisc_pkg::NODE_W-1:0]         node_index_i,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  input  logic signed [COORD_BITS-1:0]        point_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pisc_pkg::NODE_W-1:0]         node_out_o,
  output logic                                inside_res_o,
  input  logic                                cfg_we_i,
  input  logic [pisc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pisc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned NS    = pisc_pkg::N_STAGES;
  localparam int unsigned DOT_W = COORD_BITS + 19;
  localparam int unsigned CR_W  = COORD_BITS + 18;
  localparam int unsigned SQ_W  = 2 * COORD_BITS + 38;

  // configuration
  pisc_pkg::shape_e                     kind_q;
  logic signed [COORD_BITS-1:0]         cen_x_q, cen_y_q, cen_z_q;
  logic [pisc_pkg::AXIS_PACK_W-1:0]     axis_q;
  logic [COORD_BITS-1:0]                size_a_q, size_b_q, size_c_q;
  logic [2*COORD_BITS-1:0]              size_a_sq_q;

  // pipe control
  logic [NS-1:0]                        vld_q, vld_d, rdy;
  logic [pisc_pkg::NODE_W-1:0]          node_q [NS];

  // between stage groups
  logic signed [DOT_W-1:0]              f_dot, m_dot;
  logic signed [CR_W-1:0]               f_cx, f_cy, f_cz;
  logic signed [COORD_BITS:0]           f_ry, f_rz;
  logic                                 f_sph;
  logic [SQ_W-1:0]                      m_sumsq;
  pisc_pkg::test_flags_t                m_flags;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= pisc_pkg::SHAPE_SPHERE;
      cen_x_q     <= '0;
      cen_y_q     <= '0;
      cen_z_q     <= '0;
      axis_q      <= '0;
      size_a_q    <= '0;
      size_b_q    <= '0;
      size_c_q    <= '0;
      size_a_sq_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pisc_pkg::cfg_reg_e'(cfg_idx_i))
        pisc_pkg::REG_SHAPE_KIND:  kind_q   <= pisc_pkg::shape_e'(cfg_data_i[1:0]);
        pisc_pkg::REG_CENTER_X:    cen_x_q  <= cfg_data_i[COORD_BITS-1:0];
        pisc_pkg::REG_CENTER_Y:    cen_y_q  <= cfg_data_i[COORD_BITS-1:0];
        pisc_pkg::REG_CENTER_Z:    cen_z_q  <= cfg_data_i[COORD_BITS-1:0];
        pisc_pkg::REG_AXIS_PACKED: axis_q   <= cfg_data_i[pisc_pkg::AXIS_PACK_W-1:0];
        pisc_pkg::REG_SIZE_A: begin
          size_a_q    <= cfg_data_i[COORD_BITS-1:0];
          size_a_sq_q <= (2*COORD_BITS)'(cfg_data_i[COORD_BITS-1:0])
                       * (2*COORD_BITS)'(cfg_data_i[COORD_BITS-1:0]);
        end
        pisc_pkg::REG_SIZE_B:      size_b_q <= cfg_data_i[COORD_BITS-1:0];
        pisc_pkg::REG_SIZE_C:      size_c_q <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or the next one moves on
  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // node index rides alongside
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      node_q[0] <= node_index_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        node_q[k] <= node_q[k-1];
      end
    end
  end

  pisc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .en_i        (rdy[2:0]),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .center_x_i  (cen_x_q),
    .center_y_i  (cen_y_q),
    .center_z_i  (cen_z_q),
    .axis_i      (axis_q),
    .size_a_sq_i (size_a_sq_q),
    .dot_o       (f_dot),
    .cross_x_o   (f_cx),
    .cross_y_o   (f_cy),
    .cross_z_o   (f_cz),
    .ry_o        (f_ry),
    .rz_o        (f_rz),
    .sph_ok_o    (f_sph)
  );

  pisc_mid #(
    .COORD_BITS (COORD_BITS)
  ) u_mid (
    .clk_i     (clk_i),
    .en_i      (rdy[4:3]),
    .dot_i     (f_dot),
    .cross_x_i (f_cx),
    .cross_y_i (f_cy),
    .cross_z_i (f_cz),
    .ry_i      (f_ry),
    .rz_i      (f_rz),
    .sph_ok_i  (f_sph),
    .axis_i    (axis_q),
    .size_a_i  (size_a_q),
    .size_b_i  (size_b_q),
    .size_c_i  (size_c_q),
    .dot_o     (m_dot),
    .sumsq_o   (m_sumsq),
    .flags_o   (m_flags)
  );

  pisc_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .en_i        (rdy[6:5]),
    .dot_i       (m_dot),
    .sumsq_i     (m_sumsq),
    .flags_i     (m_flags),
    .size_b_i    (size_b_q),
    .size_a_sq_i (size_a_sq_q),
    .kind_i      (kind_q),
    .inside_o    (inside_res_o)
  );

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign node_out_o  = node_q[NS-1];

endmodule

FILE: sim/point_in_solid_classifier_core_tb.sv
module point_in_solid_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB         = pisc_pkg::COORD_BITS_DEF;
  localparam int unsigned NW         = pisc_pkg::NODE_W;
  localparam int unsigned AXW        = pisc_pkg::AXIS_PACK_W;
  localparam int unsigned CDW        = pisc_pkg::CFG_DATA_W;
  localparam int unsigned AXF        = pisc_pkg::AXIS_FRAC;
  localparam int unsigned LIMIT_CYC  = 400000;
  localparam int unsigned DRAIN_CYC  = pisc_pkg::N_STAGES + 4;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic          hit;
  } verdict_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [NW-1:0]                    node_index_i = '0;
  logic signed [CB-1:0]             point_x_i = '0;
  logic signed [CB-1:0]             point_y_i = '0;
  logic signed [CB-1:0]             point_z_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [NW-1:0]                    node_out_o;
  logic                             inside_res_o;
  logic                             cfg_we_i = 1'b0;
  logic [pisc_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CDW-1:0]                   cfg_data_i = '0;

  // shadow copy of the solid description
  pisc_pkg::shape_e       sh_kind;
  logic signed [CB-1:0]   sh_cx, sh_cy, sh_cz;
  logic [AXW-1:0]         sh_axis;
  logic [CB-1:0]          sh_a, sh_b, sh_c;

  verdict_t pending_verdicts[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_inside = 0;
  int unsigned cycle_cnt = 0;
  logic        quiet = 1'b0;
  logic [NW-1:0] next_node = '0;

  point_in_solid_classifier_core u_top (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYC) begin
      $display("FAIL point_in_solid_classifier_core");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 11);
  end

  // verdict for one node against the shadow solid, exact wide integers
  function automatic logic solid_contains(logic signed [CB-1:0] px,
                                          logic signed [CB-1:0] py,
                                          logic signed [CB-1:0] pz);
    longint rx, ry, rz, nx, ny, nz, dot, kx, ky, kz, adot;
    wide_t  sa, sb, sc, rel_sq, crs_sq, twice, lhs, sec_z, sec_y;
    rx = longint'(px) - longint'(sh_cx);
    ry = longint'(py) - longint'(sh_cy);
    rz = longint'(pz) - longint'(sh_cz);
    nx = longint'($signed(sh_axis[15:0]));
    ny = longint'($signed(sh_axis[31:16]));
    nz = longint'($signed(sh_axis[47:32]));
    dot = rx * nx + ry * ny + rz * nz;
    kx = ry * nz - rz * ny;
    ky = rz * nx - rx * nz;
    kz = rx * ny - ry * nx;
    adot = (dot < 0) ? -dot : dot;
    twice = wide_t'(adot) <<< 1;
    sa = wide_t'({1'b0, sh_a});
    sb = wide_t'({1'b0, sh_b});
    sc = wide_t'({1'b0, sh_c});
    rel_sq = wide_t'(rx) * wide_t'(rx) + wide_t'(ry) * wide_t'(ry)
           + wide_t'(rz) * wide_t'(rz);
    crs_sq = wide_t'(kx) * wide_t'(kx) + wide_t'(ky) * wide_t'(ky)
           + wide_t'(kz) * wide_t'(kz);
    case (sh_kind)
      pisc_pkg::SHAPE_SPHERE: return rel_sq <= sa * sa;
      pisc_pkg::SHAPE_CYLINDER:
        return (crs_sq <= (sa <<< AXF) * (sa <<< AXF)) &&
               (twice <= (sb <<< AXF));
      pisc_pkg::SHAPE_BOX: begin
        // offset projected onto the plane normal to the axis
        sec_z = (wide_t'(rz) <<< 28) - wide_t'(nz) * wide_t'(dot);
        sec_y = (wide_t'(ry) <<< 28) - wide_t'(ny) * wide_t'(dot);
        if (sec_z < 0) sec_z = -sec_z;
        if (sec_y < 0) sec_y = -sec_y;
        return (twice <= (sc <<< AXF)) &&
               ((sec_z <<< 1) <= (sa <<< 28)) &&
               ((sec_y <<< 1) <= (sb <<< 28));
      end
      default: begin
        if (dot < 0 || wide_t'(dot) > (sa <<< AXF)) return 1'b0;
        if (sh_b == '0) return 1'b1;
        lhs = crs_sq * (sb <<< 2);
        if (lhs >= (wide_t'(1) <<< 128)) return 1'b0;
        return lhs <= (wide_t'(dot) <<< (2 * pisc_pkg::FRAC_BITS_DEF + AXF));
      end
    endcase
  endfunction

  // register write, only while the pipe is empty
  task automatic write_reg(pisc_pkg::cfg_reg_e idx, logic [CDW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      pisc_pkg::REG_SHAPE_KIND:  sh_kind = pisc_pkg::shape_e'(val[1:0]);
      pisc_pkg::REG_CENTER_X:    sh_cx   = val[CB-1:0];
      pisc_pkg::REG_CENTER_Y:    sh_cy   = val[CB-1:0];
      pisc_pkg::REG_CENTER_Z:    sh_cz   = val[CB-1:0];
      pisc_pkg::REG_AXIS_PACKED: sh_axis = val[AXW-1:0];
      pisc_pkg::REG_SIZE_A:      sh_a    = val[CB-1:0];
      pisc_pkg::REG_SIZE_B:      sh_b    = val[CB-1:0];
      default:                   sh_c    = val[CB-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_solid(pisc_pkg::shape_e k, logic [CB-1:0] cx, logic [CB-1:0] cy,
                           logic [CB-1:0] cz, logic [AXW-1:0] ax,
                           logic [CB-1:0] a, logic [CB-1:0] b, logic [CB-1:0] c);
    write_reg(pisc_pkg::REG_SHAPE_KIND, CDW'(k));
    write_reg(pisc_pkg::REG_CENTER_X, CDW'(cx));
    write_reg(pisc_pkg::REG_CENTER_Y, CDW'(cy));
    write_reg(pisc_pkg::REG_CENTER_Z, CDW'(cz));
    write_reg(pisc_pkg::REG_AXIS_PACKED, ax);
    write_reg(pisc_pkg::REG_SIZE_A, CDW'(a));
    write_reg(pisc_pkg::REG_SIZE_B, CDW'(b));
    write_reg(pisc_pkg::REG_SIZE_C, CDW'(c));
  endtask

  // drop valid, then let every beat in flight come out before touching the registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // one beat on the input channel; returns after it is taken
  task automatic send_node(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                           logic signed [CB-1:0] pz);
    logic stalled;
    verdict_t v;
    if (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    node_index_i <= next_node;
    point_x_i    <= px;
    point_y_i    <= py;
    point_z_i    <= pz;
    v.node = next_node;
    v.hit  = solid_contains(px, py, pz);
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_verdicts.insert(pending_verdicts.size(), v);
    n_sent++;
    next_node = NW'($urandom);
  endtask

  // result checker: sampled mid-cycle, taken at the next edge
  always @(negedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with nothing expected: node %0h", node_out_o);
        n_errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        n_checked++;
        if (inside_res_o) n_inside++;
        if (node_out_o !== exp_v.node) begin
          $error("node_out: expected %0h, got %0h", exp_v.node, node_out_o);
          n_errors++;
        end
        if (inside_res_o !== exp_v.hit) begin
          $error("inside_res: expected %0b, got %0b (node %0h)",
                 exp_v.hit, inside_res_o, exp_v.node);
          n_errors++;
        end
      end
    end
  end

  localparam logic [AXW-1:0] AX_X = 48'h0000_0000_4000;
  localparam logic [AXW-1:0] AX_Z = 48'h4000_0000_0000;

  task automatic test_sphere();
    // radius 2.0 about the origin, boundary counted inside
    set_solid(pisc_pkg::SHAPE_SPHERE, '0, '0, '0, '0, 24'h000200, '0, '0);
    send_node('0, '0, '0);
    send_node(24'sh000200, '0, '0);
    send_node(24'sh000201, '0, '0);
    send_node(24'sh800000, 24'sh800000, 24'sh800000);
    send_node(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    drain();
    // largest radius with the centre at the negative extreme
    set_solid(pisc_pkg::SHAPE_SPHERE, 24'h800000, 24'h800000, 24'h800000, '0,
              24'hFFFFFF, '0, '0);
    send_node(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_node(24'sh800000, 24'sh7FFFFF, 24'sh800000);
    drain();
  endtask

  task automatic test_cylinder();
    set_solid(pisc_pkg::SHAPE_CYLINDER, '0, '0, '0, AX_Z, 24'h000100, 24'h000400, '0);
    send_node(24'sh000100, '0, 24'sh000200);
    send_node(24'sh000101, '0, '0);
    send_node('0, '0, 24'sh000201);
    send_node('0, '0, -24'sh000200);
    drain();
    // zero axis: dot and cross vanish, so every node is inside
    write_reg(pisc_pkg::REG_AXIS_PACKED, '0);
    send_node(24'sh7FFFFF, 24'sh800000, 24'sh123456);
    drain();
  endtask

  task automatic test_box();
    // axis not of unit length is used as written
    set_solid(pisc_pkg::SHAPE_BOX, '0, '0, '0, 48'h0000_2000_2000, 24'h000400,
              24'h000200, 24'h000300);
    send_node('0, '0, '0);
    send_node(24'sh000100, '0, 24'sh000200);
    send_node('0, 24'sh000101, 24'sh000201);
    send_node(24'sh000300, 24'sh000300, '0);
    drain();
  endtask

  task automatic test_dish();
    set_solid(pisc_pkg::SHAPE_DISH, '0, '0, '0, AX_X, 24'h000400, '0, '0);
    // zero focal length: only the depth range matters
    send_node('0, 24'sh7FFFFF, '0);
    send_node(24'sh000400, '0, 24'sh800000);
    send_node(-24'sh000001, '0, '0);
    drain();
    write_reg(pisc_pkg::REG_SIZE_B, CDW'(24'h000100));
    send_node(24'sh000400, 24'sh000100, '0);
    send_node(24'sh000400, 24'sh000080, '0);
    send_node(24'sh000401, '0, '0);
    drain();
    write_reg(pisc_pkg::REG_SIZE_B, CDW'(24'hFFFFFF));
    send_node(24'sh000400, 24'sh7FFFFF, 24'sh800000);
    drain();
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CB-1:0] rand_size();
    case ($urandom_range(0, 4))
      0: return CB'($urandom_range(0, 255));
      1: return CB'($urandom_range(0, 16'hFFFF));
      2: return CB'($urandom);
      3: return '0;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic [CB-1:0] near(logic [CB-1:0] c, logic [CB-1:0] span);
    int unsigned s;
    s = (span == '0) ? 32'd16 : 32'(span);
    return c + CB'($urandom_range(0, 2 * s) - s);
  endfunction

  task automatic test_random(int unsigned n_sets, int unsigned per_set);
    logic [CB-1:0] span;
    for (int unsigned s = 0; s < n_sets; s++) begin
      set_solid(pisc_pkg::shape_e'($urandom_range(0, 3)), CB'($urandom), CB'($urandom),
                CB'($urandom), {rand_comp(), rand_comp(), rand_comp()},
                rand_size(), rand_size(), rand_size());
      quiet = (s == n_sets / 2);
      span  = (sh_a > sh_b) ? sh_a : sh_b;
      if (sh_c > span) span = sh_c;
      for (int unsigned i = 0; i < per_set; i++) begin
        if ($urandom_range(0, 99) < 80)
          send_node(near(sh_cx, span), near(sh_cy, span), near(sh_cz, span));
        else
          send_node(CB'($urandom), CB'($urandom), CB'($urandom));
      end
      drain();
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    sh_kind = pisc_pkg::SHAPE_SPHERE;
    {sh_cx, sh_cy, sh_cz, sh_axis, sh_a, sh_b, sh_c} = '0;
    @(posedge clk_i);
    test_sphere();
    test_cylinder();
    test_box();
    test_dish();
    test_random(37, 50);
    drain();
    $display("Classified %0d nodes over all four solids, %0d checked, %0d inside.",
             n_sent, n_checked, n_inside);
    $display("Directed boundaries, degenerate axes and random solids with stalls.");
    if (n_errors == 0 && pending_verdicts.size() == 0) begin
      $display("PASS point_in_solid_classifier_core");
    end else begin
      $display("FAIL point_in_solid_classifier_core");
    end
    $finish;
  end

endmodule
